// File: sv/wvn_pkg.sv
// ---------------------------------------------------------------------------
// wvn_pkg: shared constants for the weighted vertex normalizer
// Widths of the normalized magnitudes, the square-root datapath and the
// item queue, plus default parameter values.
// ---------------------------------------------------------------------------
package wvn_pkg;

   localparam int DEF_WEIGHT_BITS = 8;
   localparam int DEF_FRAC_BITS   = 14;

   // the largest normalized magnitude sits in [2^23, 2^24)
   localparam int NORM_BITS = 24;
   localparam int NORM_TOP  = 23;

   // sum of three squares of normalized magnitudes, and the sqrt radicand
   localparam int SQ_BITS   = 2 * NORM_BITS + 2;
   localparam int RAD_SHIFT = 12;
   localparam int RAD_BITS  = SQ_BITS + RAD_SHIFT;
   localparam int ROOT_BITS = RAD_BITS / 2;
   localparam int REM_BITS  = ROOT_BITS + 3;

   // queue between front and back
   localparam int FIFO_DEPTH = 4;

   // hemisphere side register codes
   localparam logic [1:0] SIDE_POS = 2'b01;

endpackage

// File: sv/wvn_front.sv
// ---------------------------------------------------------------------------
// wvn_front: weighted corner sum and classification
// Forms the three weighted sums, applies the hemisphere rule and flags a
// zero vector. Two register stages, never stalls.
// ---------------------------------------------------------------------------
module wvn_front #(
   parameter int WEIGHT_BITS = wvn_pkg::DEF_WEIGHT_BITS,
   parameter int COORD_BITS  = wvn_pkg::DEF_FRAC_BITS + 2,
   parameter int SUM_BITS    = WEIGHT_BITS + COORD_BITS + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [WEIGHT_BITS-1:0]       weight [3],
   input  logic signed [COORD_BITS-1:0] coord [9],
   input  logic [1:0]                   side,
   output logic [1:0]                   inflight,
   output logic                         push,
   output logic signed [SUM_BITS-1:0]   sum_out [3],
   output logic                         zero_out
);
   import wvn_pkg::*;

   localparam int PROD_BITS = WEIGHT_BITS + COORD_BITS + 1;

   logic                        prod_vld_ff;
   logic signed [PROD_BITS-1:0] prod_ff [9];
   logic signed [SUM_BITS-1:0]  sum_in [3];
   logic                        zero_in;
   logic                        push_ff;
   logic signed [SUM_BITS-1:0]  sum_ff [3];
   logic                        zero_ff;

   // stage 1: nine products
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[3*k+i] <= $signed({1'b0, weight[k]}) * coord[3*k+i];
         end
      end
      if (reset) prod_vld_ff <= 1'b0;
      else       prod_vld_ff <= accept;
   end

   // stage 2: sums, hemisphere rule, zero check
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = SUM_BITS'(prod_ff[i]) + SUM_BITS'(prod_ff[3+i]) + SUM_BITS'(prod_ff[6+i]);
      end
      if ((side == SIDE_POS && sum_in[2] > 0) || (side[1] && sum_in[2] < 0)) begin
         sum_in[2] = '0;
      end
      zero_in = (sum_in[0] == 0) && (sum_in[1] == 0) && (sum_in[2] == 0);
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      zero_ff <= zero_in;
      if (reset) push_ff <= 1'b0;
      else       push_ff <= prod_vld_ff;
   end

   assign inflight = {1'b0, prod_vld_ff} + {1'b0, push_ff};
   assign push     = push_ff;
   assign sum_out  = sum_ff;
   assign zero_out = zero_ff;

endmodule

// File: sv/wvn_fifo.sv
// ---------------------------------------------------------------------------
// wvn_fifo: small item queue between front and back
// Register-based, one write and one read per cycle.
// ---------------------------------------------------------------------------
module wvn_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = wvn_pkg::FIFO_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import wvn_pkg::*;

   localparam int PB = $clog2(DEPTH);
   localparam int CB = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PB-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CB-1:0]    count_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_data;
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= (wr_ptr_ff == PB'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (rd_en) rd_ptr_ff <= (rd_ptr_ff == PB'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_ff <= count_ff + CB'(wr_en) - CB'(rd_en);
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign count   = count_ff;

endmodule

// File: sv/wvn_sqrt.sv
// ---------------------------------------------------------------------------
// wvn_sqrt: pipelined integer square root
// One root bit per stage, floor result, side payload carried along.
// ---------------------------------------------------------------------------
module wvn_sqrt #(
   parameter int PW = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [wvn_pkg::RAD_BITS-1:0]   in_rad,
   input  logic [PW-1:0]                  in_pay,
   output logic                           out_valid,
   output logic [wvn_pkg::ROOT_BITS-1:0]  out_root,
   output logic [PW-1:0]                  out_pay
);
   import wvn_pkg::*;

   logic                 vld_ff  [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [RAD_BITS-1:0]  rad_ff  [ROOT_BITS];
   logic [PW-1:0]        pay_ff  [ROOT_BITS];

   logic [REM_BITS-1:0]  rem_in  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_in [ROOT_BITS];

   // each stage: bring down two radicand bits, try 4r+1
   always_comb begin
      logic [REM_BITS-1:0]  rem_p;
      logic [ROOT_BITS-1:0] root_p;
      logic [RAD_BITS-1:0]  rad_p;
      logic [REM_BITS-1:0]  cur;
      logic [REM_BITS-1:0]  trial;
      for (int k = 0; k < ROOT_BITS; k++) begin
         rem_p  = (k == 0) ? '0 : rem_ff[(k == 0) ? 0 : k-1];
         root_p = (k == 0) ? '0 : root_ff[(k == 0) ? 0 : k-1];
         rad_p  = (k == 0) ? in_rad : rad_ff[(k == 0) ? 0 : k-1];
         cur    = {rem_p[REM_BITS-3:0], rad_p[RAD_BITS-1 -: 2]};
         trial  = REM_BITS'({root_p, 2'b01});
         if (cur >= trial) begin
            rem_in[k]  = cur - trial;
            root_in[k] = {root_p[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in[k]  = cur;
            root_in[k] = {root_p[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ROOT_BITS; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         if (k == 0) begin
            rad_ff[k] <= in_rad << 2;
            pay_ff[k] <= in_pay;
         end else begin
            rad_ff[k] <= rad_ff[(k == 0) ? 0 : k-1] << 2;
            pay_ff[k] <= pay_ff[(k == 0) ? 0 : k-1];
         end
      end
      if (reset) begin
         for (int k = 0; k < ROOT_BITS; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < ROOT_BITS; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   assign out_valid = vld_ff[ROOT_BITS-1];
   assign out_root  = root_ff[ROOT_BITS-1];
   assign out_pay   = pay_ff[ROOT_BITS-1];

endmodule

// File: sv/wvn_div.sv
// ---------------------------------------------------------------------------
// wvn_div: pipelined rounded divide a * 2^(FRAC_BITS+6) / L
// Restoring division, one quotient bit per stage, payload carried along.
// ---------------------------------------------------------------------------
module wvn_div #(
   parameter int FRAC_BITS = wvn_pkg::DEF_FRAC_BITS,
   parameter int PW        = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [wvn_pkg::NORM_BITS-1:0] in_mag,
   input  logic [wvn_pkg::ROOT_BITS-1:0] in_den,
   input  logic [PW-1:0]                 in_pay,
   output logic                          out_valid,
   output logic [FRAC_BITS+1:0]          out_quo,
   output logic [PW-1:0]                 out_pay
);
   import wvn_pkg::*;

   localparam int QW   = FRAC_BITS + 2;
   localparam int NW   = NORM_BITS + FRAC_BITS + 7;
   localparam int DREM = ROOT_BITS + 1;

   logic [NW-1:0]        num_in;
   logic                 vld_ff [QW+1];
   logic [DREM-1:0]      rem_ff [QW+1];
   logic [QW-1:0]        low_ff [QW+1];
   logic [QW-1:0]        quo_ff [QW+1];
   logic [ROOT_BITS-1:0] den_ff [QW+1];
   logic [PW-1:0]        pay_ff [QW+1];
   logic [DREM-1:0]      rem_in [QW+1];
   logic                 ge_in  [QW+1];

   // rounded numerator; quotient fits QW bits, so the top part is below L
   assign num_in = (NW'(in_mag) << (FRAC_BITS + 6)) + NW'(in_den >> 1);

   always_comb begin
      logic [DREM-1:0] cur;
      rem_in[0] = '0;
      ge_in[0]  = 1'b0;
      for (int k = 1; k <= QW; k++) begin
         cur       = {rem_ff[k-1][DREM-2:0], low_ff[k-1][QW-1]};
         ge_in[k]  = cur >= {1'b0, den_ff[k-1]};
         rem_in[k] = ge_in[k] ? cur - {1'b0, den_ff[k-1]} : cur;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= DREM'(num_in[NW-1:QW]);
      low_ff[0] <= num_in[QW-1:0];
      quo_ff[0] <= '0;
      den_ff[0] <= in_den;
      pay_ff[0] <= in_pay;
      for (int k = 1; k <= QW; k++) begin
         rem_ff[k] <= rem_in[k];
         low_ff[k] <= low_ff[k-1] << 1;
         quo_ff[k] <= {quo_ff[k-1][QW-2:0], ge_in[k]};
         den_ff[k] <= den_ff[k-1];
         pay_ff[k] <= pay_ff[k-1];
      end
      if (reset) begin
         for (int k = 0; k <= QW; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= QW; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_pay   = pay_ff[QW];

endmodule

// File: sv/wvn_back.sv
// ---------------------------------------------------------------------------
// wvn_back: normalization pipeline
// Magnitudes, block shift into [2^23,2^24), sum of squares, square root,
// three dividers, clamp to 1.0, sign restore and zero-vector override.
// ---------------------------------------------------------------------------
module wvn_back #(
   parameter int FRAC_BITS = wvn_pkg::DEF_FRAC_BITS,
   parameter int SUM_BITS  = wvn_pkg::DEF_WEIGHT_BITS + wvn_pkg::DEF_FRAC_BITS + 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [SUM_BITS-1:0]   in_sum [3],
   input  logic                         in_zero,
   output logic                         out_valid,
   output logic signed [FRAC_BITS+1:0]  out_vec [3],
   output logic                         out_zero
);
   import wvn_pkg::*;

   localparam int MAG_BITS = SUM_BITS - 1;
   localparam int PB       = $clog2(MAG_BITS);
   localparam int SW       = MAG_BITS + NORM_TOP;
   localparam int SQB      = 2 * NORM_BITS;
   localparam int PAYW     = 3 * NORM_BITS + 4;
   localparam int QW       = FRAC_BITS + 2;
   localparam int CW       = FRAC_BITS + 2;

   // stage 1: sign and magnitude
   logic                v1_ff, z1_ff;
   logic [2:0]          neg1_ff;
   logic [MAG_BITS-1:0] mag1_ff [3];
   logic [SUM_BITS-1:0] abs_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_in[i] = in_sum[i][SUM_BITS-1] ? SUM_BITS'(-in_sum[i]) : SUM_BITS'(in_sum[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         neg1_ff[i] <= in_sum[i][SUM_BITS-1];
         mag1_ff[i] <= abs_in[i][MAG_BITS-1:0];
      end
      z1_ff <= in_zero;
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= in_valid;
   end

   // stage 2: leading one of the largest magnitude
   logic                v2_ff, z2_ff;
   logic [2:0]          neg2_ff;
   logic [MAG_BITS-1:0] mag2_ff [3];
   logic [PB-1:0]       pos2_ff;
   logic [MAG_BITS-1:0] orv_in;
   logic [PB-1:0]       pos_in;

   always_comb begin
      orv_in = mag1_ff[0] | mag1_ff[1] | mag1_ff[2];
      pos_in = '0;
      for (int i = 0; i < MAG_BITS; i++) begin
         if (orv_in[i]) pos_in = PB'(i);
      end
   end

   always_ff @(posedge clock) begin
      mag2_ff <= mag1_ff;
      neg2_ff <= neg1_ff;
      z2_ff   <= z1_ff;
      pos2_ff <= pos_in;
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
   end

   // stage 3: shift so the leading one lands on bit 23 (right shift truncates)
   logic                 v3_ff, z3_ff;
   logic [2:0]           neg3_ff;
   logic [NORM_BITS-1:0] a3_ff [3];
   logic [SW-1:0]        shv_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shv_in[i] = (SW'(mag2_ff[i]) << NORM_TOP) >> pos2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) a3_ff[i] <= shv_in[i][NORM_BITS-1:0];
      neg3_ff <= neg2_ff;
      z3_ff   <= z2_ff;
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
   end

   // stage 4: squares
   logic                 v4_ff, z4_ff;
   logic [2:0]           neg4_ff;
   logic [NORM_BITS-1:0] a4_ff [3];
   logic [SQB-1:0]       sq4_ff [3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) sq4_ff[i] <= a3_ff[i] * a3_ff[i];
      a4_ff   <= a3_ff;
      neg4_ff <= neg3_ff;
      z4_ff   <= z3_ff;
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
   end

   // stage 5: sum of squares
   logic                 v5_ff;
   logic [SQ_BITS-1:0]   s5_ff;
   logic [PAYW-1:0]      pay5_ff;

   always_ff @(posedge clock) begin
      s5_ff   <= SQ_BITS'(sq4_ff[0]) + SQ_BITS'(sq4_ff[1]) + SQ_BITS'(sq4_ff[2]);
      pay5_ff <= {a4_ff[0], a4_ff[1], a4_ff[2], neg4_ff, z4_ff};
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
   end

   // square root of S * 2^12
   logic                 sq_vld;
   logic [ROOT_BITS-1:0] len;
   logic [PAYW-1:0]      sq_pay;

   wvn_sqrt #(.PW(PAYW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_rad    ({s5_ff, {RAD_SHIFT{1'b0}}}),
      .in_pay    (pay5_ff),
      .out_valid (sq_vld),
      .out_root  (len),
      .out_pay   (sq_pay)
   );

   // three dividers in parallel
   logic [NORM_BITS-1:0] a_s [3];
   logic [2:0]           neg_s;
   logic                 z_s;
   logic [2:0]           dv_vld;
   logic [QW-1:0]        quo [3];
   logic [1:0]           px;
   logic                 py, pz;

   assign {a_s[0], a_s[1], a_s[2], neg_s, z_s} = sq_pay;

   wvn_div #(.FRAC_BITS(FRAC_BITS), .PW(2)) u_div_x (
      .clock(clock), .reset(reset), .in_valid(sq_vld), .in_mag(a_s[0]), .in_den(len),
      .in_pay({neg_s[0], z_s}), .out_valid(dv_vld[0]), .out_quo(quo[0]), .out_pay(px)
   );
   wvn_div #(.FRAC_BITS(FRAC_BITS), .PW(1)) u_div_y (
      .clock(clock), .reset(reset), .in_valid(sq_vld), .in_mag(a_s[1]), .in_den(len),
      .in_pay(neg_s[1]), .out_valid(dv_vld[1]), .out_quo(quo[1]), .out_pay(py)
   );
   wvn_div #(.FRAC_BITS(FRAC_BITS), .PW(1)) u_div_z (
      .clock(clock), .reset(reset), .in_valid(sq_vld), .in_mag(a_s[2]), .in_den(len),
      .in_pay(neg_s[2]), .out_valid(dv_vld[2]), .out_quo(quo[2]), .out_pay(pz)
   );

   // output stage: clamp to 1.0, restore sign, zero-vector override
   localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

   logic                 vo_ff, zo_ff;
   logic signed [CW-1:0] vec_ff [3];
   logic [2:0]           neg_o;
   logic [QW-1:0]        qc_in [3];

   assign neg_o = {px[1], py, pz};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qc_in[i] = (quo[i] > ONE) ? ONE : quo[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (px[0])            vec_ff[i] <= '0;
         else if (neg_o[2-i])  vec_ff[i] <= -$signed(CW'(qc_in[i]));
         else                  vec_ff[i] <= $signed(CW'(qc_in[i]));
      end
      zo_ff <= px[0];
      if (reset) vo_ff <= 1'b0;
      else       vo_ff <= &dv_vld;
   end

   assign out_valid = vo_ff;
   assign out_vec   = vec_ff;
   assign out_zero  = zo_ff;

endmodule

// File: sv/weighted_vertex_normalize.sv
// ---------------------------------------------------------------------------
// weighted_vertex_normalize: weighted corner sum normalized to unit length
//
// Request: an item is taken on a rising edge with start high and busy low.
// It carries three unsigned weights and three corners in signed fixed point
// with FRAC_BITS fraction bits. Response: rsp_valid is high for exactly one
// cycle per item with the unit vector and the zero_length flag; the
// receiver cannot hold results off. Items leave in arrival order.
// Throughput: one item per cycle. An item passes 2 front stages, the queue,
// 5 back stages, 31 square-root stages (one root bit each), FRAC_BITS+3
// divider stages and one output register. busy rises only if the queue
// together with items in the front would overflow, which a free-running
// back end never allows.
// csr: one write port for hemisphere_side, always ready; write it while no
// item is in flight. Reset clears the register to 0 (mode off) and
// empties every pipeline stage and the queue.
// ---------------------------------------------------------------------------
module weighted_vertex_normalize #(
   parameter int WEIGHT_BITS = wvn_pkg::DEF_WEIGHT_BITS,
   parameter int FRAC_BITS   = wvn_pkg::DEF_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [WEIGHT_BITS-1:0]      req_weight_a,
   input  logic [WEIGHT_BITS-1:0]      req_weight_b,
   input  logic [WEIGHT_BITS-1:0]      req_weight_c,
   input  logic signed [FRAC_BITS+1:0] req_ax,
   input  logic signed [FRAC_BITS+1:0] req_ay,
   input  logic signed [FRAC_BITS+1:0] req_az,
   input  logic signed [FRAC_BITS+1:0] req_bx,
   input  logic signed [FRAC_BITS+1:0] req_by_coord,
   input  logic signed [FRAC_BITS+1:0] req_bz,
   input  logic signed [FRAC_BITS+1:0] req_cx,
   input  logic signed [FRAC_BITS+1:0] req_cy,
   input  logic signed [FRAC_BITS+1:0] req_cz,
   output logic                        rsp_valid,
   output logic signed [FRAC_BITS+1:0] rsp_out_x,
   output logic signed [FRAC_BITS+1:0] rsp_out_y,
   output logic signed [FRAC_BITS+1:0] rsp_out_z,
   output logic                        rsp_zero_length,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic signed [1:0]           csr_hemisphere_side
);
   import wvn_pkg::*;

   localparam int COORD_BITS = FRAC_BITS + 2;
   localparam int SUM_BITS   = WEIGHT_BITS + COORD_BITS + 2;
   localparam int QDW        = 3 * SUM_BITS + 1;
   localparam int CB         = $clog2(FIFO_DEPTH + 1);
   localparam int TB         = CB + 1;

   // hemisphere side register
   logic [1:0] side_ff;

   always_ff @(posedge clock) begin
      if (reset)          side_ff <= '0;
      else if (csr_valid) side_ff <= csr_hemisphere_side;
   end

   assign csr_ready = 1'b1;

   // front end
   logic                         accept;
   logic [WEIGHT_BITS-1:0]       weight [3];
   logic signed [COORD_BITS-1:0] coord [9];
   logic [1:0]                   inflight;
   logic                         push;
   logic signed [SUM_BITS-1:0]   f_sum [3];
   logic                         f_zero;

   assign accept = start && !busy;
   assign weight = '{req_weight_a, req_weight_b, req_weight_c};
   assign coord  = '{req_ax, req_ay, req_az, req_bx, req_by_coord, req_bz,
                     req_cx, req_cy, req_cz};

   wvn_front #(
      .WEIGHT_BITS(WEIGHT_BITS), .COORD_BITS(COORD_BITS), .SUM_BITS(SUM_BITS)
   ) u_front (
      .clock(clock), .reset(reset), .accept(accept), .weight(weight), .coord(coord),
      .side(side_ff), .inflight(inflight), .push(push), .sum_out(f_sum), .zero_out(f_zero)
   );

   // queue between front and back
   logic [QDW-1:0] q_rd;
   logic           q_empty;
   logic [CB-1:0]  q_count;

   wvn_fifo #(.WIDTH(QDW), .DEPTH(FIFO_DEPTH)) u_fifo (
      .clock(clock), .reset(reset), .wr_en(push),
      .wr_data({f_sum[0], f_sum[1], f_sum[2], f_zero}),
      .rd_en(!q_empty), .rd_data(q_rd), .empty(q_empty), .count(q_count)
   );

   // hold off requests when queue plus front stages could overflow
   assign busy = (TB'(q_count) + TB'(inflight)) >= TB'(FIFO_DEPTH);

   // back end
   logic signed [SUM_BITS-1:0]   b_sum [3];
   logic                         b_zero;
   logic signed [COORD_BITS-1:0] b_vec [3];

   assign {b_sum[0], b_sum[1], b_sum[2], b_zero} = q_rd;

   wvn_back #(.FRAC_BITS(FRAC_BITS), .SUM_BITS(SUM_BITS)) u_back (
      .clock(clock), .reset(reset), .in_valid(!q_empty), .in_sum(b_sum), .in_zero(b_zero),
      .out_valid(rsp_valid), .out_vec(b_vec), .out_zero(rsp_zero_length)
   );

   assign rsp_out_x = b_vec[0];
   assign rsp_out_y = b_vec[1];
   assign rsp_out_z = b_vec[2];

endmodule

// File: sv/wvn_checker.sv
// ---------------------------------------------------------------------------
// wvn_checker: port-level checks for the weighted vertex normalizer
// Watches the response and csr ports; bound to the top level.
// ---------------------------------------------------------------------------
module wvn_checker #(
   parameter int FRAC_BITS = wvn_pkg::DEF_FRAC_BITS
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic signed [FRAC_BITS+1:0] rsp_out_x,
   input logic signed [FRAC_BITS+1:0] rsp_out_y,
   input logic signed [FRAC_BITS+1:0] rsp_out_z,
   input logic                        rsp_zero_length,
   input logic                        csr_ready
);
   import wvn_pkg::*;

   localparam logic signed [FRAC_BITS+1:0] ONE  = (FRAC_BITS+2)'(1) << FRAC_BITS;
   localparam logic signed [FRAC_BITS+1:0] MONE = -ONE;

   // no result strobe right after a reset cycle
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result strobe after reset");

   // zero vector gives all-zero outputs
   a_zero_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |-> rsp_out_x == 0 && rsp_out_y == 0 && rsp_out_z == 0)
      else $error("zero_length with nonzero outputs");

   // nonzero vector never normalizes to all zero
   a_nonzero_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_length |-> rsp_out_x != 0 || rsp_out_y != 0 || rsp_out_z != 0)
      else $error("nonzero vector gave zero outputs");

   // every component within +-1.0
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_x <= ONE && rsp_out_x >= MONE && rsp_out_y <= ONE &&
                    rsp_out_y >= MONE && rsp_out_z <= ONE && rsp_out_z >= MONE)
      else $error("component outside unit range");

   // csr port is always open
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready) else $error("csr port not ready");

endmodule

bind weighted_vertex_normalize wvn_checker #(.FRAC_BITS(FRAC_BITS)) u_wvn_checker (.*);

// File: test/weighted_vertex_normalize_tb.sv
// ---------------------------------------------------------------------------
// weighted_vertex_normalize_tb: self-checking bench for the vertex normalizer
// A directed table (zero vectors, axis corners, field extremes) runs first.
// It is followed by random phases over every hemisphere side setting and
// several sender idle patterns. Each result is checked against a built-in
// fixed-point normalization predictor.
// ---------------------------------------------------------------------------
module weighted_vertex_normalize_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wvn_pkg::*;

   localparam int WB = DEF_WEIGHT_BITS;
   localparam int FB = DEF_FRAC_BITS;
   localparam int CB = FB + 2;
   localparam int ONE = 1 << FB;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 100;
   localparam logic signed [1:0] SIDE_OFF = 2'sb00;
   localparam logic signed [1:0] SIDE_NEG = 2'sb11;
   localparam logic signed [1:0] SIDE_MIN = 2'sb10;

   typedef struct {
      logic [WB-1:0]        w[3];
      logic signed [CB-1:0] p[9];   // ax ay az bx by bz cx cy cz
   } corner_item_t;

   typedef struct {
      logic signed [CB-1:0] v[3];
      logic                 zl;
   } unit_vector_t;

   typedef struct {
      corner_item_t item;
      bit           typed;
      unit_vector_t want;
   } table_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy, rsp_valid, rsp_zero_length, csr_valid = 1'b0, csr_ready;
   logic [WB-1:0] w_a = '0, w_b = '0, w_c = '0;
   logic signed [CB-1:0] crd[9] = '{default: '0};
   logic signed [CB-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic signed [1:0] csr_side = SIDE_OFF;

   logic signed [1:0] model_side = SIDE_OFF;
   unit_vector_t pending_normals[$];
   table_row_t directed_rows[$];
   int fail_count = 0;
   int cycle_count = 0;
   int results_seen = 0;
   int zero_seen = 0;

   weighted_vertex_normalize DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_weight_a(w_a), .req_weight_b(w_b), .req_weight_c(w_c),
      .req_ax(crd[0]), .req_ay(crd[1]), .req_az(crd[2]),
      .req_bx(crd[3]), .req_by_coord(crd[4]), .req_bz(crd[5]),
      .req_cx(crd[6]), .req_cy(crd[7]), .req_cz(crd[8]),
      .rsp_valid(rsp_valid), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z), .rsp_zero_length(rsp_zero_length),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_hemisphere_side(csr_side)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // integer square root, bit by bit
   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // weighted corner sum, hemisphere clip, scale to unit length
   function automatic unit_vector_t predict_normal(input corner_item_t it,
                                                   input logic signed [1:0] side);
      unit_vector_t res;
      longint sum[3] = '{0, 0, 0};
      longint unsigned mag[3], mx, sq, len, q;
      bit neg[3];
      mx = 0;
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++)
            sum[i] += longint'(it.w[k]) * longint'(it.p[3*k+i]);
      if ((side > 0 && sum[2] > 0) || (side < 0 && sum[2] < 0)) sum[2] = 0;
      res.zl = (sum[0] == 0 && sum[1] == 0 && sum[2] == 0);
      res.v = '{default: '0};
      if (res.zl) return res;
      for (int i = 0; i < 3; i++) begin
         neg[i] = sum[i] < 0;
         mag[i] = neg[i] ? -sum[i] : sum[i];
         if (mag[i] > mx) mx = mag[i];
      end
      while (mx >= (64'd1 << 24)) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (mx < (64'd1 << 23)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      sq = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
      len = int_sqrt(sq << 12);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << (FB + 6)) + (len >> 1)) / len;
         if (q > ONE) q = ONE;
         res.v[i] = neg[i] ? -CB'(q) : CB'(q);
      end
      return res;
   endfunction

   // result checker: one result per strobe, oldest expectation first
   always @(posedge clock) begin
      unit_vector_t exp_v;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_normals.size() == 0) begin
            $error("result with no item outstanding");
            fail_count++;
         end else begin
            exp_v = pending_normals.pop_front();
            results_seen++;
            if (exp_v.zl) zero_seen++;
            if (rsp_out_x !== exp_v.v[0]) begin
               $error("out_x exp %0d got %0d", exp_v.v[0], rsp_out_x);
               fail_count++;
            end
            if (rsp_out_y !== exp_v.v[1]) begin
               $error("out_y exp %0d got %0d", exp_v.v[1], rsp_out_y);
               fail_count++;
            end
            if (rsp_out_z !== exp_v.v[2]) begin
               $error("out_z exp %0d got %0d", exp_v.v[2], rsp_out_z);
               fail_count++;
            end
            if (rsp_zero_length !== exp_v.zl) begin
               $error("zero_length exp %0b got %0b", exp_v.zl, rsp_zero_length);
               fail_count++;
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("weighted_vertex_normalize: mismatch");
         $finish;
      end
   end

   // drive one item from a falling edge; returns at the falling edge after it is taken
   task automatic send_item(input corner_item_t it, input bit typed,
                            input unit_vector_t want);
      unit_vector_t pred;
      bit was_busy;
      pred = predict_normal(it, model_side);
      if (typed && (pred.v[0] !== want.v[0] || pred.v[1] !== want.v[1] ||
                    pred.v[2] !== want.v[2] || pred.zl !== want.zl)) begin
         $error("typed row disagrees with predictor");
         fail_count++;
      end
      start <= 1'b1;
      w_a <= it.w[0];
      w_b <= it.w[1];
      w_c <= it.w[2];
      for (int i = 0; i < 9; i++) crd[i] <= it.p[i];
      do begin
         was_busy = busy;
         @(negedge clock);
      end while (was_busy);
      pending_normals.push_back(typed ? want : pred);
   endtask

   task automatic idle_cycle();
      start <= 1'b0;
      @(negedge clock);
   endtask

   // wait for the pipeline to empty
   task automatic drain();
      start <= 1'b0;
      while (pending_normals.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_side(input logic signed [1:0] side);
      bit rdy;
      csr_valid <= 1'b1;
      csr_side <= side;
      do begin
         rdy = csr_ready;
         @(negedge clock);
      end while (!rdy);
      model_side = side;
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [CB-1:0] rand_coord(input int kind);
      case (kind)
         0: return CB'($urandom);
         1: return $urandom_range(1) ? CB'(ONE) : -CB'(ONE);
         default: return CB'(int'($urandom_range(2 * ONE)) - ONE);
      endcase
   endfunction

   function automatic corner_item_t rand_item();
      corner_item_t it;
      int kind = $urandom_range(99);
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(7))
            0: it.w[k] = '0;
            1: it.w[k] = '1;
            default: it.w[k] = WB'($urandom);
         endcase
      end
      for (int i = 0; i < 9; i++) begin
         if (kind < 10) it.p[i] = rand_coord(0);
         else if (kind < 18) it.p[i] = $urandom_range(1) ? rand_coord(1) : '0;
         else if (kind < 28 && (i % 3) != 2) it.p[i] = '0;   // z-only vectors
         else it.p[i] = rand_coord(2);
      end
      return it;
   endfunction

   task automatic add_row(input int wa, wb, wc, input int p[9], input bit typed,
                          input int ex, ey, ez, input bit zl);
      table_row_t r;
      r.item.w = '{WB'(wa), WB'(wb), WB'(wc)};
      for (int i = 0; i < 9; i++) r.item.p[i] = CB'(p[i]);
      r.typed = typed;
      r.want.v = '{CB'(ex), CB'(ey), CB'(ez)};
      r.want.zl = zl;
      directed_rows.push_back(r);
   endtask

   initial begin
      int idle_pct[4] = '{0, 56, 16, 0};
      logic signed [1:0] sides[8] = '{SIDE_POS, SIDE_NEG, SIDE_MIN, SIDE_OFF,
                                      SIDE_POS, SIDE_MIN, SIDE_NEG, SIDE_OFF};
      unit_vector_t none;
      none.v = '{default: '0};
      none.zl = 1'b0;

      // directed table: typed rows where the answer is obvious, then untyped rows
      add_row(0, 0, 0, '{ONE, ONE, ONE, 5, 6, 7, -1, -2, -3}, 1, 0, 0, 0, 1);
      add_row(255, 255, 255, '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0, 0, 1);
      add_row(1, 0, 0, '{ONE, 0, 0, 9, 9, 9, 9, 9, 9}, 1, ONE, 0, 0, 0);
      add_row(0, 1, 0, '{9, 9, 9, 0, -ONE, 0, 9, 9, 9}, 1, 0, -ONE, 0, 0);
      add_row(0, 0, 255, '{9, 9, 9, 9, 9, 9, 0, 0, ONE}, 1, 0, 0, ONE, 0);
      add_row(3, 3, 0, '{ONE, -ONE, 5, -ONE, ONE, -5, 0, 0, 0}, 1, 0, 0, 0, 1);
      add_row(255, 0, 0, '{-ONE, 0, 0, 0, 0, 0, 0, 0, 0}, 1, -ONE, 0, 0, 0);
      add_row(255, 255, 255, '{32767, 32767, 32767, 32767, 32767, 32767,
              32767, 32767, 32767}, 0, 0, 0, 0, 0);
      add_row(255, 255, 255, '{-32768, -32768, -32768, -32768, -32768, -32768,
              -32768, -32768, -32768}, 0, 0, 0, 0, 0);
      add_row(255, 1, 128, '{32767, -32768, 1, -1, 0, -32768, 100, 200, 300},
              0, 0, 0, 0, 0);
      add_row(1, 1, 1, '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 0, 0, 0, 0, 0);
      add_row(1, 2, 4, '{1, 0, 0, 0, 1, 0, 0, 0, -1}, 0, 0, 0, 0, 0);
      add_row(170, 85, 15, '{-21846, 21845, 4660, 1, -1, 2, -3, 4, -5},
              0, 0, 0, 0, 0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[n])
         send_item(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].want);
      drain();

      // random phases: one side setting and one idle pattern each
      for (int ph = 0; ph < 8; ph++) begin
         repeat (DRAIN_CYCLES) @(negedge clock);
         write_side(sides[ph]);
         for (int n = 0; n < 56; n++) begin
            while (int'($urandom_range(99)) < idle_pct[ph % 4]) idle_cycle();
            if (ph == 3 && n == 28) drain();   // hold off until all results are back
            send_item(rand_item(), 1'b0, none);
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d results (%0d zero vectors) over all hemisphere sides",
               results_seen, zero_seen);
      $display("sender idle patterns: none, 56%%, 16%%; one full drain mid-phase");
      if (fail_count == 0 && pending_normals.size() == 0)
         $display("weighted_vertex_normalize: match");
      else
         $display("weighted_vertex_normalize: mismatch");
      $finish;
   end
endmodule
